// File: sv/geometry_param_lagrange_eval_macros.svh
// Assertion macros for the Lagrange evaluator.
// Used by the top level only; no other dependencies.
`ifndef GEOMETRY_PARAM_LAGRANGE_EVAL_MACROS_SVH
`define GEOMETRY_PARAM_LAGRANGE_EVAL_MACROS_SVH

// Check that a condition implies a property on the next edge.
`define GPLE_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

// Check that a condition implies a property in the same cycle.
`define GPLE_ASSERT_NOW(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

`endif

// File: sv/gple_pkg.sv
// Shared constants and types for the Lagrange evaluator.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package gple_pkg;
  localparam int TablePoints = 8;
  localparam int IdxW = $clog2(TablePoints);
  localparam int CntW = $clog2(TablePoints + 1);
  localparam int XW = 20;
  localparam int VW = 48;
  localparam int MemW = XW + VW;

  localparam logic [1:0] OP_EVAL = 2'd0;
  localparam logic [1:0] OP_LOAD_W = 2'd1;
  localparam logic [1:0] OP_LOAD_L = 2'd2;

  localparam logic [1:0] DEP_MUL = 2'd1;
  localparam logic [1:0] DEP_DIV = 2'd2;

  localparam logic [2:0] REG_MIN_LENGTH = 3'd0;
  localparam logic [2:0] REG_MIN_WIDTH = 3'd1;
  localparam logic [2:0] REG_LENGTH_OFFSET = 3'd2;
  localparam logic [2:0] REG_WIDTH_OFFSET = 3'd3;
  localparam logic [2:0] REG_LENGTH_DEP = 3'd4;
  localparam logic [2:0] REG_WIDTH_DEP = 3'd5;
  localparam logic [2:0] REG_WIDTH_POINTS = 3'd6;
  localparam logic [2:0] REG_LENGTH_POINTS = 3'd7;

  localparam logic signed [VW-1:0] VMax = {1'b0, {(VW-1){1'b1}}};
  localparam logic signed [VW-1:0] VMin = {1'b1, {(VW-1){1'b0}}};

  typedef logic signed [VW-1:0] value_t;
endpackage
`default_nettype wire

// File: sv/gple_ram.sv
// Generic single-port-write, single-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module gple_ram #(
  parameter int Width = 8,
  parameter int Depth = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]              rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: sv/geometry_param_lagrange_eval.sv
// Top level of the clamped Lagrange geometry parameter evaluator.
// Depends on gple_pkg, gple_ram and geometry_param_lagrange_eval_macros.svh.
//
// Usage: pulse start with operation and payload while busy is low. Load
// requests (operation 1 or 2) write one table point (abscissa and value) into
// the width or length table RAM and leave busy low, with no result.
// Operation 3 is dropped. An evaluate request raises busy until the single
// result appears on value and the three flags with done high for one cycle;
// the receiver cannot stall, so the result is simply presented once.
//
// Evaluation: each interpolation reads point i, then every other point j
// (address, then registered data), and runs one multiply-divide on the shared
// unit per other point with a different abscissa. Each unit operation runs
// four 25x25 partial products, a setup step, a 98-step restoring divide and
// a finish step. The worst case does three 8-point table lookups, plus one
// combine and two scaling steps; a lookup-only mode does one lookup.
// Configuration writes go to flat registers; the user must write them only
// while the block is idle; the block itself does not enforce it. Reset clears
// the registers and the controller; the tables stay undefined until loaded.
`timescale 1ns / 1ps
`default_nettype none
`include "geometry_param_lagrange_eval_macros.svh"
module geometry_param_lagrange_eval (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  operation,
  input  wire logic [2:0]  point_index,
  input  wire logic [19:0] point_x,
  input  wire logic signed [47:0] point_value,
  input  wire logic [19:0] length,
  input  wire logic [19:0] width,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [19:0] cfg_data,
  output logic             done,
  output logic signed [47:0] value,
  output logic             length_offset_error,
  output logic             width_offset_error,
  output logic             table_missing
);
  // Controller states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SETUP = 4'd1;  // pick the next table lookup
  localparam logic [3:0] S_RDI   = 4'd2;  // wait for point i read
  localparam logic [3:0] S_RDJ   = 4'd3;  // wait for point j read
  localparam logic [3:0] S_MD    = 4'd4;  // muldiv running
  localparam logic [3:0] S_ACC   = 4'd5;  // add term to sum
  localparam logic [3:0] S_CLAMP = 4'd6;
  localparam logic [3:0] S_SCALE = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;

  // Configuration registers
  logic [19:0] min_length, min_width, length_offset, width_offset;
  logic [1:0]  length_dependence, width_dependence;
  logic [3:0]  width_points, length_points;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_length <= '0;
      min_width <= '0;
      length_offset <= '0;
      width_offset <= '0;
      length_dependence <= '0;
      width_dependence <= '0;
      width_points <= '0;
      length_points <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        gple_pkg::REG_MIN_LENGTH:    min_length <= cfg_data;
        gple_pkg::REG_MIN_WIDTH:     min_width <= cfg_data;
        gple_pkg::REG_LENGTH_OFFSET: length_offset <= cfg_data;
        gple_pkg::REG_WIDTH_OFFSET:  width_offset <= cfg_data;
        gple_pkg::REG_LENGTH_DEP:    length_dependence <= cfg_data[1:0];
        gple_pkg::REG_WIDTH_DEP:     width_dependence <= cfg_data[1:0];
        gple_pkg::REG_WIDTH_POINTS:  width_points <= cfg_data[3:0];
        gple_pkg::REG_LENGTH_POINTS: length_points <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Table memories: {x, value} per entry
  logic accept;
  logic [3:0] state;
  logic [gple_pkg::IdxW-1:0] raddr;
  logic [gple_pkg::MemW-1:0] wt_rdata, lt_rdata;
  logic in_range;

  assign accept = start && !busy;
  assign in_range = ({1'b0, point_index} < 4'(gple_pkg::TablePoints));

  gple_ram #(.Width(gple_pkg::MemW), .Depth(gple_pkg::TablePoints)) u_wtab (
    .clk(clk),
    .we(accept && operation == gple_pkg::OP_LOAD_W && in_range),
    .waddr(point_index[gple_pkg::IdxW-1:0]),
    .wdata({point_x, point_value}),
    .raddr(raddr),
    .rdata(wt_rdata)
  );

  gple_ram #(.Width(gple_pkg::MemW), .Depth(gple_pkg::TablePoints)) u_ltab (
    .clk(clk),
    .we(accept && operation == gple_pkg::OP_LOAD_L && in_range),
    .waddr(point_index[gple_pkg::IdxW-1:0]),
    .wdata({point_x, point_value}),
    .raddr(raddr),
    .rdata(lt_rdata)
  );

  // Request registers
  logic [19:0] req_l, req_w;
  logic [1:0]  mode;       // 0 width only, 1 length only, 2 both
  logic [1:0]  lookup;     // which lookup of the request is running
  logic        use_len;    // current lookup reads the length table
  logic [20:0] eval_x;
  logic [gple_pkg::CntW-1:0] n, i, j;
  logic [19:0] xi;
  logic signed [47:0] t, sum_lo, sum_hi;
  logic signed [51:0] sum;
  logic signed [47:0] wv, lm, res;
  logic [1:0] scale_step;
  logic missing;
  logic [gple_pkg::MemW-1:0] rd;

  assign rd = use_len ? lt_rdata : wt_rdata;

  // Shared multiply-divide unit: trunc(a*b/c), saturating
  logic        md_start, md_busy;
  logic        md_neg, md_ovf;
  logic [48:0] md_a, md_b, md_c;
  logic [97:0] md_p;
  logic [48:0] md_r;
  logic [48:0] md_q;
  logic [6:0]  md_cnt;
  logic [1:0]  md_phase;
  logic [1:0]  md_pp;      // partial product being added
  logic [24:0] md_pa, md_pb;
  logic [49:0] md_pprod;
  logic signed [47:0] md_res;
  logic signed [48:0] ma, mb, mc;
  logic [49:0] md_rs;

  assign md_pa = md_pp[0] ? {1'b0, md_a[48:25]} : md_a[24:0];
  assign md_pb = md_pp[1] ? {1'b0, md_b[48:25]} : md_b[24:0];
  assign md_pprod = md_pa * md_pb;

  always_ff @(posedge clk) begin
    if (rst) begin
      md_busy <= 1'b0;
      md_phase <= '0;
    end else if (md_start) begin
      md_busy <= 1'b1;
      md_phase <= 2'd0;
      md_pp <= 2'd0;
      md_neg <= (ma < 0) ^ (mb < 0) ^ (mc < 0);
      md_a <= (ma < 0) ? 49'(-ma) : 49'(ma);
      md_b <= (mb < 0) ? 49'(-mb) : 49'(mb);
      md_c <= (mc < 0) ? 49'(-mc) : 49'(mc);
    end else if (md_busy) begin
      case (md_phase)
        2'd0: begin
          // Accumulate the four 25x25 partial products
          case (md_pp)
            2'd0:    md_p <= 98'(md_pprod);
            2'd3:    md_p <= md_p + {md_pprod[47:0], 50'd0};
            default: md_p <= md_p + {23'd0, md_pprod, 25'd0};
          endcase
          md_pp <= md_pp + 2'd1;
          if (md_pp == 2'd3) md_phase <= 2'd1;
        end
        2'd1: begin
          md_phase <= 2'd2;
          md_cnt <= 7'd97;
          md_r <= '0;
          md_q <= '0;
          md_ovf <= 1'b0;
        end
        2'd2: begin
          md_r <= md_rs >= {1'b0, md_c} ? 49'(md_rs - {1'b0, md_c}) : md_rs[48:0];
          md_q <= {md_q[47:0], md_rs >= {1'b0, md_c}};
          if (md_q[48] || md_q[47]) md_ovf <= 1'b1;
          md_p <= {md_p[96:0], 1'b0};
          if (md_cnt == 7'd0) md_phase <= 2'd3;
          else md_cnt <= md_cnt - 7'd1;
        end
        default: md_busy <= 1'b0;
      endcase
    end
  end

  assign md_rs = {md_r, md_p[97]};

  always_comb begin
    logic [48:0] lim;
    lim = md_neg ? 49'h0_8000_0000_0000 : 49'h0_7FFF_FFFF_FFFF;
    if (md_ovf || md_q > lim) md_res = md_neg ? gple_pkg::VMin : gple_pkg::VMax;
    else md_res = md_neg ? 48'(-md_q) : md_q[47:0];
  end

  // Next lookup descriptor
  always_comb begin
    use_len = 1'b0;
    eval_x = {1'b0, req_w};
    case (mode)
      2'd0: ;
      2'd1: begin use_len = 1'b1; eval_x = {1'b0, req_l}; end
      default: begin
        if (lookup == 2'd1) begin use_len = 1'b1; eval_x = {1'b0, min_length}; end
        else if (lookup == 2'd2) begin use_len = 1'b1; eval_x = {1'b0, req_l}; end
      end
    endcase
  end

  logic [3:0] nw_c, nl_c;
  assign nw_c = (width_points > 4'(gple_pkg::TablePoints)) ? 4'(gple_pkg::TablePoints)
                                                            : width_points;
  assign nl_c = (length_points > 4'(gple_pkg::TablePoints)) ? 4'(gple_pkg::TablePoints)
                                                             : length_points;

  logic signed [20:0] dl, dw, dd;
  assign dl = $signed({1'b0, req_l}) - $signed({1'b0, length_offset});
  assign dw = $signed({1'b0, req_w}) - $signed({1'b0, width_offset});
  assign dd = $signed({1'b0, xi}) - $signed({1'b0, rd[gple_pkg::MemW-1:gple_pkg::VW]});

  logic [1:0] dep;
  logic signed [20:0] diff;
  assign dep = (scale_step == 2'd0) ? length_dependence : width_dependence;
  assign diff = (scale_step == 2'd0) ? dl : dw;

  logic [gple_pkg::CntW-1:0] j_next;
  assign j_next = (j + 1'b1 == i) ? j + 2'd2 : j + 1'b1;

  // Start the unit once per operation: only with fresh read data in the
  // factor loop, and only before the wait begins when combining or scaling.
  always_comb begin
    md_start = 1'b0;
    ma = 49'(t);
    mb = 49'(signed'(eval_x) - signed'({1'b0, rd[gple_pkg::MemW-1:gple_pkg::VW]}));
    mc = 49'(dd);
    if (state == S_RDJ && md_wait && dd != 0) md_start = 1'b1;
    if (state == S_SCALE) begin
      ma = 49'(res);
      mb = (dep == gple_pkg::DEP_MUL) ? 49'(diff) : 49'sd1;
      mc = (dep == gple_pkg::DEP_MUL) ? 49'sd1 : 49'(diff);
      md_start = !md_wait && !md_busy && (dep == gple_pkg::DEP_MUL ||
                 (dep == gple_pkg::DEP_DIV && diff != 0));
    end
    if (state == S_CLAMP && mode == 2'd2 && lookup == 2'd2) begin
      ma = 49'(wv);
      mb = 49'(sum > 52'(sum_hi) ? sum_hi : (sum < 52'(sum_lo) ? sum_lo : 48'(sum)));
      mc = 49'(lm);
      md_start = !md_wait && (lm != 0);
    end
  end

  logic signed [47:0] clamped;
  assign clamped = (n == 0) ? '0 :
                   (sum > 52'(sum_hi)) ? sum_hi :
                   (sum < 52'(sum_lo)) ? sum_lo : 48'(sum);

  logic md_wait;  // read data, combine or scaling result pending

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done <= 1'b0;
      md_wait <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept && operation == gple_pkg::OP_EVAL) begin
            req_l <= length;
            req_w <= width;
            lookup <= '0;
            if (length == min_length) mode <= 2'd0;
            else if (width == min_width) mode <= 2'd1;
            else mode <= 2'd2;
            state <= S_SETUP;
          end
        end
        S_SETUP: begin
          n <= use_len ? nl_c[gple_pkg::CntW-1:0] : nw_c[gple_pkg::CntW-1:0];
          i <= '0;
          sum <= '0;
          raddr <= '0;
          if ((use_len ? nl_c : nw_c) == 4'd0) state <= S_CLAMP;
          else state <= S_RDI;
        end
        S_RDI: begin
          if (raddr == i[gple_pkg::IdxW-1:0] && !md_wait) begin
            md_wait <= 1'b1; // data for point i arrives next cycle
          end else begin
            md_wait <= 1'b0;
            xi <= rd[gple_pkg::MemW-1:gple_pkg::VW];
            t <= rd[gple_pkg::VW-1:0];
            if (i == 0) begin
              sum_lo <= rd[gple_pkg::VW-1:0];
              sum_hi <= rd[gple_pkg::VW-1:0];
            end else begin
              if ($signed(rd[gple_pkg::VW-1:0]) < sum_lo) sum_lo <= rd[gple_pkg::VW-1:0];
              if ($signed(rd[gple_pkg::VW-1:0]) > sum_hi) sum_hi <= rd[gple_pkg::VW-1:0];
            end
            j <= (i == 0) ? gple_pkg::CntW'(1) : '0;
            if (n == 1) state <= S_ACC;
            else begin
              raddr <= (i == 0) ? gple_pkg::IdxW'(1) : '0;
              state <= S_RDJ;
            end
          end
        end
        S_RDJ: begin
          if (!md_wait) begin
            md_wait <= 1'b1;
          end else begin
            md_wait <= 1'b0;
            state <= (dd != 0) ? S_MD : S_RDJ;
            if (dd == 0) begin
              j <= j_next;
              raddr <= j_next[gple_pkg::IdxW-1:0];
              if (j_next >= n) state <= S_ACC;
            end
          end
        end
        S_MD: begin
          if (!md_busy) begin
            t <= md_res;
            j <= j_next;
            raddr <= j_next[gple_pkg::IdxW-1:0];
            state <= (j_next >= n) ? S_ACC : S_RDJ;
          end
        end
        S_ACC: begin
          sum <= sum + 52'(t);
          if (i + 1'b1 == n) state <= S_CLAMP;
          else begin
            i <= i + 1'b1;
            raddr <= gple_pkg::IdxW'(i + 1'b1);
            state <= S_RDI;
          end
        end
        S_CLAMP: begin
          if (md_wait) begin
            if (!md_busy && !md_start) begin
              md_wait <= 1'b0;
              res <= md_res;
              scale_step <= '0;
              state <= S_SCALE;
            end
          end else if (mode != 2'd2) begin
            res <= clamped;
            missing <= (n == 0);
            scale_step <= '0;
            state <= S_SCALE;
          end else if (lookup == 2'd0) begin
            wv <= clamped;
            missing <= (n == 0);
            lookup <= 2'd1;
            state <= S_SETUP;
          end else if (lookup == 2'd1) begin
            lm <= clamped;
            missing <= missing | (n == 0);
            lookup <= 2'd2;
            state <= S_SETUP;
          end else begin
            missing <= missing | (n == 0);
            if (lm != 0) md_wait <= 1'b1;
            else begin
              res <= '0;
              scale_step <= '0;
              state <= S_SCALE;
            end
          end
        end
        S_SCALE: begin
          if (md_wait) begin
            if (!md_busy) begin
              md_wait <= 1'b0;
              res <= md_res;
              if (scale_step == 2'd1) state <= S_OUT;
              scale_step <= scale_step + 1'b1;
            end
          end else if (md_start) begin
            md_wait <= 1'b1;
          end else begin
            if (dep == gple_pkg::DEP_DIV)
              res <= (res > 0) ? gple_pkg::VMax : ((res < 0) ? gple_pkg::VMin : '0);
            if (scale_step == 2'd1) state <= S_OUT;
            scale_step <= scale_step + 1'b1;
          end
        end
        S_OUT: begin
          done <= 1'b1;
          value <= res;
          length_offset_error <= (dl <= 0);
          width_offset_error <= (dw <= 0);
          table_missing <= missing;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign busy = (state != S_IDLE);

  // Assertions
  `GPLE_ASSERT_NEXT(a_done_pulse, done, !done, "done held for two cycles")
  `GPLE_ASSERT_NOW(a_done_idle, done, !busy, "result shown while busy")
  `GPLE_ASSERT_NOW(a_md_start_free, md_start, !md_busy,
                   "multiply-divide started while running")
endmodule
`default_nettype wire

// File: tb/tb.sv
// Self-checking bench for geometry_param_lagrange_eval: table loads, evaluate
// requests and register settings, each result checked against a local model.
// Depends on gple_pkg and the geometry_param_lagrange_eval RTL.
`timescale 1ns / 1ps
module tb;
  localparam logic [1:0] OP_NONE  = 2'd3;   // dropped by the block
  localparam logic [1:0] DEP_NONE = 2'd0;
  localparam int         STALL_LIMIT = 200000;
  localparam int         TARGET_ITEMS = 1800;

  typedef struct {
    logic [1:0]  op;
    logic [2:0]  idx;
    logic [19:0] px;
    gple_pkg::value_t pv;
    logic [19:0] len;
    logic [19:0] wid;
  } request_t;

  typedef struct {
    gple_pkg::value_t val;
    logic   len_err;
    logic   wid_err;
    logic   missing;
  } eval_result_t;

  logic clk, rst, start, busy, done, cfg_we;
  logic [1:0]  operation;
  logic [2:0]  point_index, cfg_index;
  logic [19:0] point_x, length, width, cfg_data;
  logic signed [47:0] point_value, value;
  logic length_offset_error, width_offset_error, table_missing;

  geometry_param_lagrange_eval uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .operation(operation), .point_index(point_index), .point_x(point_x),
    .point_value(point_value), .length(length), .width(width),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .done(done), .value(value), .length_offset_error(length_offset_error),
    .width_offset_error(width_offset_error), .table_missing(table_missing)
  );

  // Local copy of the block's registers and tables.
  logic [19:0] m_min_len, m_min_wid, m_len_off, m_wid_off;
  logic [1:0]  m_len_dep, m_wid_dep;
  logic [3:0]  m_wid_pts, m_len_pts;
  logic [19:0]      wtab_x [gple_pkg::TablePoints];
  gple_pkg::value_t wtab_v [gple_pkg::TablePoints];
  logic [19:0]      ltab_x [gple_pkg::TablePoints];
  gple_pkg::value_t ltab_v [gple_pkg::TablePoints];

  request_t     pending_reqs[$];
  eval_result_t expected_results[$];
  request_t     cur;
  int errors, n_req, n_eval, n_res, stall_cnt;
  bit idle_ok;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // trunc(a*b/c), saturated to 48 bits
  function automatic longint mul_div(longint a, longint b, longint c);
    bit neg;
    logic [63:0]  ua, ub, uc;
    logic [127:0] q;
    logic [63:0]  lim;
    begin
      neg = (a < 0) != (b < 0);
      if (c < 0) neg = !neg;
      ua = (a < 0) ? -a : a;
      ub = (b < 0) ? -b : b;
      uc = (c < 0) ? -c : c;
      q = ({64'd0, ua} * {64'd0, ub}) / {64'd0, uc};
      lim = neg ? 64'h8000_0000_0000 : 64'h7FFF_FFFF_FFFF;
      if (q > {64'd0, lim}) q = {64'd0, lim};
      mul_div = neg ? -longint'(q[63:0]) : longint'(q[63:0]);
    end
  endfunction

  // Clamped Lagrange lookup in the width table (use_w) or the length table.
  function automatic longint lagrange(bit use_w, logic [3:0] cnt, longint x);
    int n;
    longint sum, lo, hi, t, d, xi, xj;
    begin
      n = (cnt > gple_pkg::TablePoints) ? gple_pkg::TablePoints : cnt;
      sum = 0;
      if (n == 0) return 0;
      lo = use_w ? wtab_v[0] : ltab_v[0];
      hi = lo;
      for (int i = 0; i < n; i++) begin
        t = use_w ? wtab_v[i] : ltab_v[i];
        xi = use_w ? wtab_x[i] : ltab_x[i];
        if (t < lo) lo = t;
        if (t > hi) hi = t;
        for (int j = 0; j < n; j++) begin
          if (j != i) begin
            xj = use_w ? wtab_x[j] : ltab_x[j];
            d = xi - xj;
            if (d != 0) t = mul_div(t, x - xj, d);
          end
        end
        sum += t;
      end
      if (sum < lo) sum = lo;
      if (sum > hi) sum = hi;
      return sum;
    end
  endfunction

  function automatic longint apply_dependence(longint v, logic [1:0] dep, longint diff);
    begin
      if (dep == gple_pkg::DEP_MUL) return mul_div(v, diff, 1);
      if (dep == gple_pkg::DEP_DIV) begin
        if (diff != 0) return mul_div(v, 1, diff);
        return (v > 0) ? longint'(gple_pkg::VMax) :
               ((v < 0) ? longint'(gple_pkg::VMin) : 0);
      end
      return v;
    end
  endfunction

  // Update the tables, or queue the expected result of an evaluate request.
  task automatic predict_request(request_t r);
    eval_result_t e;
    longint v, wv, lm, lv, dl, dw;
    begin
      if (r.op == gple_pkg::OP_LOAD_W) begin
        wtab_x[r.idx] = r.px;
        wtab_v[r.idx] = r.pv;
      end else if (r.op == gple_pkg::OP_LOAD_L) begin
        ltab_x[r.idx] = r.px;
        ltab_v[r.idx] = r.pv;
      end else if (r.op == gple_pkg::OP_EVAL) begin
        if (r.len == m_min_len) begin
          v = lagrange(1, m_wid_pts, r.wid);
          e.missing = (m_wid_pts == 0);
        end else if (r.wid == m_min_wid) begin
          v = lagrange(0, m_len_pts, r.len);
          e.missing = (m_len_pts == 0);
        end else begin
          wv = lagrange(1, m_wid_pts, r.wid);
          lm = lagrange(0, m_len_pts, m_min_len);
          lv = lagrange(0, m_len_pts, r.len);
          v = (lm != 0) ? mul_div(wv, lv, lm) : 0;
          e.missing = (m_wid_pts == 0) || (m_len_pts == 0);
        end
        dl = longint'(r.len) - longint'(m_len_off);
        dw = longint'(r.wid) - longint'(m_wid_off);
        v = apply_dependence(v, m_len_dep, dl);
        v = apply_dependence(v, m_wid_dep, dw);
        e.val = v[47:0];
        e.len_err = (dl <= 0);
        e.wid_err = (dw <= 0);
        expected_results.push_back(e);
        n_eval++;
      end
    end
  endtask

  task automatic report_mismatch(string what, longint got, longint exp);
    begin
      $display("MISMATCH %0t: %s got %0d expected %0d", $realtime, what, got, exp);
      errors++;
    end
  endtask

  // Driver: present the next request, hold it until accepted, idle at random.
  // Keep a clean stretch without idling in the middle of the run.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        predict_request(cur);
        n_req++;
      end
      if (!start || !busy) begin
        idle_ok = (n_req < 700 || n_req > 1000) && ($urandom_range(99) < 7);
        if (pending_reqs.size() > 0 && !idle_ok) begin
          cur = pending_reqs.pop_front();
          operation <= cur.op;
          point_index <= cur.idx;
          point_x <= cur.px;
          point_value <= cur.pv;
          length <= cur.len;
          width <= cur.wid;
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: each done pulse is one result; compare with the oldest prediction.
  always @(posedge clk) begin
    eval_result_t e;
    if (!rst && done) begin
      n_res++;
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result, value", value, 0);
      end else begin
        e = expected_results.pop_front();
        if (value !== e.val) report_mismatch("value", value, e.val);
        if (length_offset_error !== e.len_err)
          report_mismatch("length_offset_error", length_offset_error, e.len_err);
        if (width_offset_error !== e.wid_err)
          report_mismatch("width_offset_error", width_offset_error, e.wid_err);
        if (table_missing !== e.missing)
          report_mismatch("table_missing", table_missing, e.missing);
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cnt <= 0;
    end else begin
      stall_cnt <= stall_cnt + 1;
      if (stall_cnt == STALL_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  function automatic gple_pkg::value_t rand_value();
    begin
      case ($urandom_range(3))
        0: rand_value = 48'({$urandom, $urandom});
        1: rand_value = $signed(48'($urandom_range(200))) <<< 24;
        2: rand_value = -($signed(48'($urandom_range(200))) <<< 24);
        default: rand_value = gple_pkg::value_t'($signed($urandom));
      endcase
    end
  endfunction

  function automatic logic [19:0] rand_geom();
    begin
      case ($urandom_range(9))
        0: rand_geom = 20'd1;
        1: rand_geom = 20'hFFFFF;
        2: rand_geom = 20'($urandom_range(20'hFFFFF, 1));
        default: rand_geom = 20'($urandom_range(5000, 1));
      endcase
    end
  endfunction

  task automatic push_load(logic [1:0] op, logic [2:0] idx, logic [19:0] px,
                           gple_pkg::value_t pv);
    request_t r;
    begin
      r = '{op, idx, px, pv, rand_geom(), rand_geom()};
      pending_reqs.push_back(r);
    end
  endtask

  task automatic push_eval(logic [19:0] l, logic [19:0] w);
    request_t r;
    begin
      r = '{gple_pkg::OP_EVAL, 3'($urandom), 20'($urandom),
            48'({$urandom, $urandom}), l, w};
      pending_reqs.push_back(r);
    end
  endtask

  // Write one register; the local copy follows the block.
  task automatic write_reg(logic [2:0] idx, logic [19:0] data);
    begin
      @(posedge clk);
      cfg_we <= 1'b1;
      cfg_index <= idx;
      cfg_data <= data;
      case (idx)
        gple_pkg::REG_MIN_LENGTH:    m_min_len = data;
        gple_pkg::REG_MIN_WIDTH:     m_min_wid = data;
        gple_pkg::REG_LENGTH_OFFSET: m_len_off = data;
        gple_pkg::REG_WIDTH_OFFSET:  m_wid_off = data;
        gple_pkg::REG_LENGTH_DEP:    m_len_dep = data[1:0];
        gple_pkg::REG_WIDTH_DEP:     m_wid_dep = data[1:0];
        gple_pkg::REG_WIDTH_POINTS:  m_wid_pts = data[3:0];
        default:                     m_len_pts = data[3:0];
      endcase
      @(posedge clk);
      cfg_we <= 1'b0;
    end
  endtask

  // Wait until every request is taken, every result is in and the block is idle.
  task automatic drain();
    begin
      do @(negedge clk);
      while (pending_reqs.size() > 0 || start || busy || expected_results.size() > 0);
      repeat (20) @(posedge clk);
    end
  endtask

  task automatic write_all(logic [19:0] ml, logic [19:0] mw, logic [19:0] lo,
                           logic [19:0] wo, logic [1:0] ld, logic [1:0] wd,
                           logic [3:0] wp, logic [3:0] lp);
    begin
      write_reg(gple_pkg::REG_MIN_LENGTH, ml);
      write_reg(gple_pkg::REG_MIN_WIDTH, mw);
      write_reg(gple_pkg::REG_LENGTH_OFFSET, lo);
      write_reg(gple_pkg::REG_WIDTH_OFFSET, wo);
      write_reg(gple_pkg::REG_LENGTH_DEP, {18'd0, ld});
      write_reg(gple_pkg::REG_WIDTH_DEP, {18'd0, wd});
      write_reg(gple_pkg::REG_WIDTH_POINTS, {16'd0, wp});
      write_reg(gple_pkg::REG_LENGTH_POINTS, {16'd0, lp});
    end
  endtask

  // Mostly one to three points keeps evaluations short; now and then a full table.
  function automatic logic [3:0] rand_count();
    begin
      case ($urandom_range(11))
        0: rand_count = 4'd0;
        1: rand_count = 4'($urandom_range(15, 8));
        default: rand_count = 4'($urandom_range(3, 1));
      endcase
    end
  endfunction

  function automatic logic [19:0] rand_reg20();
    begin
      case ($urandom_range(4))
        0: rand_reg20 = 20'd0;
        1: rand_reg20 = 20'hFFFFF;
        default: rand_reg20 = 20'($urandom_range(5000));
      endcase
    end
  endfunction

  initial begin
    int phase, big, n_items;
    logic [19:0] l, w, base;
    rst = 1'b1;
    start = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    operation = gple_pkg::OP_EVAL;
    point_index = '0;
    point_x = '0;
    point_value = '0;
    length = 20'd1;
    width = 20'd1;
    errors = 0; n_req = 0; n_eval = 0; n_res = 0;
    m_min_len = '0; m_min_wid = '0; m_len_off = '0; m_wid_off = '0;
    m_len_dep = DEP_NONE; m_wid_dep = DEP_NONE; m_wid_pts = '0; m_len_pts = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: fill both tables at the extremes, then a dropped operation and
    // three combined lookups on fresh registers, with zero point counts in both tables.
    @(negedge clk);
    for (int i = 0; i < gple_pkg::TablePoints; i++) begin
      push_load(gple_pkg::OP_LOAD_W, 3'(i),
                (i == 0) ? 20'd0 : (i == 7) ? 20'hFFFFF : 20'(i * 100),
                (i == 1) ? gple_pkg::VMax : (i == 2) ? gple_pkg::VMin : rand_value());
      push_load(gple_pkg::OP_LOAD_L, 3'(i), (i == 0) ? 20'hFFFFF : 20'(i * 100),
                (i == 3) ? gple_pkg::VMax : (i == 4) ? gple_pkg::VMin : rand_value());
    end
    push_load(OP_NONE, 3'd7, 20'hFFFFF, gple_pkg::VMin);
    push_eval(20'd1, 20'hFFFFF);
    push_eval(20'hFFFFF, 20'd1);
    push_eval(20'd200, 20'd300);
    drain();

    // Two points sharing one abscissa, division by a zero difference.
    write_all(20'd0, 20'd0, 20'd100, 20'd300, gple_pkg::DEP_DIV, gple_pkg::DEP_MUL,
              4'd2, 4'd2);
    @(negedge clk);
    push_load(gple_pkg::OP_LOAD_W, 3'd1, 20'd0, rand_value());
    push_eval(20'd100, 20'd300);
    push_eval(20'd50, 20'd700);
    push_eval(20'hFFFFF, 20'hFFFFF);
    drain();

    // Random phases: new registers, a few table updates, a burst of lookups.
    phase = 0;
    while (n_req < TARGET_ITEMS) begin
      big = ($urandom_range(9) == 0);
      write_all(rand_reg20(), rand_reg20(), rand_reg20(), rand_reg20(),
                2'($urandom), 2'($urandom),
                big ? 4'($urandom_range(15, 8)) : rand_count(),
                big ? 4'($urandom_range(15, 8)) : rand_count());
      @(negedge clk);
      n_items = big ? 6 : $urandom_range(40, 20);
      base = 20'($urandom_range(4000));
      for (int k = 0; k < n_items; k++) begin
        case ($urandom_range(9))
          0, 1: push_load(gple_pkg::OP_LOAD_W, 3'($urandom),
                          ($urandom_range(3) == 0) ? 20'($urandom) :
                          base + 20'($urandom_range(40)), rand_value());
          2, 3: push_load(gple_pkg::OP_LOAD_L, 3'($urandom),
                          ($urandom_range(3) == 0) ? 20'($urandom) :
                          base + 20'($urandom_range(40)), rand_value());
          4: push_load(OP_NONE, 3'($urandom), 20'($urandom), rand_value());
          default: begin
            l = rand_geom();
            w = rand_geom();
            case ($urandom_range(5))
              0: l = m_min_len;
              1: w = m_min_wid;
              2: l = m_len_off;
              3: w = m_wid_off;
              default: ;
            endcase
            if (l == 0) l = 20'd1;
            if (w == 0) w = 20'd1;
            push_eval(l, w);
          end
        endcase
      end
      drain();
      phase++;
    end

    drain();
    $display("Covered %0d requests in %0d register settings: %0d lookups, %0d results.",
             n_req, phase + 2, n_eval, n_res);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
